>>> hdl/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the calendar date arithmetic block.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  typedef enum logic [1:0] {
    KIND_VALIDATE = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_SUB      = 2'd2,
    KIND_DIFF     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NEGATIVE = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request word
    logic add_step;  // one month forward
    logic sub_step;  // one month backward
    logic num_a;     // start day number of first date
    logic num_b;     // start day number of second date
    logic mon_step;  // add one earlier month length
    logic diff;      // form the difference
    logic finish;    // form the result word
  } dda_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad1;      // first date invalid
    logic range1;    // first year out of range
    logic bad2;
    logic range2;
    logic add_done;
    logic sub_done;
    logic walk_over; // year left its range while walking
    logic mon_done;  // month accumulation finished
  } dda_sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                   input logic [13:0] y);
    return (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= month_len(m, y));
  endfunction

  function automatic logic year_ok(input logic [13:0] y);
    return (y >= 14'd1) && (y <= YEAR_MAX);
  endfunction

endpackage

>>> hdl/dda_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_req_if / dda_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface dda_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  day_in;
  logic [3:0]  month_in;
  logic [13:0] year_in;
  logic [15:0] day_count;
  logic [4:0]  other_day;
  logic [3:0]  other_month;
  logic [13:0] other_year;
  modport source (output valid, kind, day_in, month_in, year_in, day_count,
                  other_day, other_month, other_year, input ready);
  modport sink (input valid, kind, day_in, month_in, year_in, day_count,
                other_day, other_month, other_year, output ready);
endinterface

interface dda_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;
  logic [21:0] day_difference;
  logic [1:0]  status;
  modport source (output valid, day_out, month_out, year_out, day_difference,
                  status, input ready);
  modport sink (input valid, day_out, month_out, year_out, day_difference,
                status, output ready);
endinterface

>>> hdl/dda_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_datapath
// Date registers, month walker and day number accumulator.
// ----------------------------------------------------------------------------
module dda_datapath (
  input  logic              clk_i,
  input  dda_pkg::dda_cmd_t cmd_i,
  input  logic [1:0]        kind_i,
  input  logic [4:0]        day_i,
  input  logic [3:0]        month_i,
  input  logic [13:0]       year_i,
  input  logic [15:0]       count_i,
  input  logic [4:0]        oday_i,
  input  logic [3:0]        omonth_i,
  input  logic [13:0]       oyear_i,
  output dda_pkg::dda_sts_t sts_o,
  output logic [4:0]        day_o,
  output logic [3:0]        month_o,
  output logic [13:0]       year_o,
  output logic [21:0]       diff_o,
  output logic [1:0]        status_o
);
  import dda_pkg::*;

  logic [1:0]  kind_q;
  logic [4:0]  d0_q, od_q;
  logic [3:0]  m0_q, om_q;
  logic [13:0] y0_q, oy_q;
  logic [16:0] d_q;       // walking day, may exceed a month
  logic [3:0]  m_q;
  logic [13:0] y_q;
  logic [15:0] k_q;
  logic        over_q;
  logic [21:0] acc_q, a_q;
  logic [3:0]  i_q;       // month index for accumulation
  logic [13:0] ay_q;      // year for accumulation
  logic [3:0]  tgt_q;     // month of the date being numbered
  logic        neg_q;

  logic [4:0]  len_cur, len_prev, len_acc;
  logic [3:0]  m_prev;
  logic [13:0] y_prev;
  logic [13:0] ym1;
  logic [21:0] base;

  always_comb begin
    len_cur  = month_len(m_q, y_q);
    m_prev   = (m_q == 4'd1) ? 4'd12 : m_q - 4'd1;
    y_prev   = (m_q == 4'd1) ? y_q - 14'd1 : y_q;
    len_prev = month_len(m_prev, y_prev);
    len_acc  = month_len(i_q, ay_q);
    ym1      = (cmd_i.num_a ? y0_q : oy_q) - 14'd1;
    base     = 22'(ym1) * 22'd365 + 22'(ym1[13:2])
             + 22'(cmd_i.num_a ? d0_q : od_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      d0_q <= day_i; m0_q <= month_i; y0_q <= year_i;
      od_q <= oday_i; om_q <= omonth_i; oy_q <= oyear_i;
      // add starts from day plus count, subtract from the day alone
      d_q  <= (kind_e'(kind_i) == KIND_ADD) ? 17'(day_i) + 17'(count_i) : 17'(day_i);
      m_q  <= month_i; y_q <= year_i;
      k_q  <= count_i;
      over_q <= 1'b0;
    end
    if (cmd_i.add_step) begin
      d_q <= d_q - 17'(len_cur);
      if (m_q == 4'd12) begin
        m_q <= 4'd1;
        y_q <= y_q + 14'd1;
        if (y_q == YEAR_MAX) over_q <= 1'b1;
      end else begin
        m_q <= m_q + 4'd1;
      end
    end
    if (cmd_i.sub_step) begin
      if (17'(k_q) < d_q) begin
        d_q <= d_q - 17'(k_q);
        k_q <= '0;
      end else begin
        k_q <= k_q - 16'(d_q);
        m_q <= m_prev;
        if (m_q == 4'd1 && y_q == 14'd1) begin
          over_q <= 1'b1;
        end else begin
          y_q <= y_prev;
          d_q <= 17'(len_prev);
        end
      end
    end
    if (cmd_i.num_a || cmd_i.num_b) begin
      acc_q <= base;
      i_q   <= 4'd1;
      ay_q  <= cmd_i.num_a ? y0_q : oy_q;
    end
    if (cmd_i.num_a) tgt_q <= m0_q;
    if (cmd_i.num_b) tgt_q <= om_q;
    if (cmd_i.mon_step) begin
      acc_q <= acc_q + 22'(len_acc);
      i_q   <= i_q + 4'd1;
    end
    if (cmd_i.num_b) a_q <= acc_q;
    if (cmd_i.diff) begin
      neg_q <= a_q < acc_q;
      acc_q <= a_q - acc_q;
    end
  end

  always_comb begin
    sts_o.bad1      = !date_ok(d0_q, m0_q, y0_q);
    sts_o.range1    = !year_ok(y0_q);
    sts_o.bad2      = !date_ok(od_q, om_q, oy_q);
    sts_o.range2    = !year_ok(oy_q);
    sts_o.add_done  = d_q <= 17'(len_cur);
    sts_o.sub_done  = k_q == 16'd0;
    sts_o.walk_over = over_q;
    sts_o.mon_done  = i_q >= tgt_q;
  end

  // result word, registered on finish
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      diff_o <= '0;
      if (sts_o.bad1) begin
        status_o <= ST_INVALID;
        day_o <= d0_q; month_o <= m0_q; year_o <= y0_q;
      end else if (sts_o.range1) begin
        status_o <= ST_RANGE;
        day_o <= '0; month_o <= '0; year_o <= '0;
      end else begin
        case (kind_e'(kind_q))
          KIND_ADD, KIND_SUB: begin
            if (over_q) begin
              status_o <= ST_RANGE;
              day_o <= '0; month_o <= '0; year_o <= '0;
            end else begin
              status_o <= ST_OK;
              day_o <= d_q[4:0]; month_o <= m_q; year_o <= y_q;
            end
          end
          KIND_DIFF: begin
            if (sts_o.bad2) begin
              status_o <= ST_INVALID;
              day_o <= d0_q; month_o <= m0_q; year_o <= y0_q;
            end else if (sts_o.range2) begin
              status_o <= ST_RANGE;
              day_o <= '0; month_o <= '0; year_o <= '0;
            end else begin
              status_o <= neg_q ? ST_NEGATIVE : ST_OK;
              diff_o <= neg_q ? '0 : acc_q;
              day_o <= d0_q; month_o <= m0_q; year_o <= y0_q;
            end
          end
          default: begin
            status_o <= ST_OK;
            day_o <= d0_q; month_o <= m0_q; year_o <= y0_q;
          end
        endcase
      end
    end
  end
endmodule

>>> hdl/dda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer: accept a word, run the walk or the day number pass if its kind needs one, hand off.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  dda_pkg::dda_sts_t sts_i,
  output dda_pkg::dda_cmd_t cmd_o
);
  import dda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ADD, S_SUB, S_NUMA, S_ACCA, S_NUMB, S_ACCB, S_DIFF, S_FIN
  } state_e;

  state_e state_q;
  logic   valid_q;
  logic [1:0] kind_q;

  // one word in the engine; the output register holds its word until taken
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    case (state_q)
      S_ADD:  cmd_o.add_step = !sts_i.add_done && !sts_i.walk_over;
      S_SUB:  cmd_o.sub_step = !sts_i.sub_done && !sts_i.walk_over;
      S_NUMA: cmd_o.num_a = 1'b1;
      S_ACCA: cmd_o.mon_step = !sts_i.mon_done;
      S_NUMB: cmd_o.num_b = 1'b1;
      S_ACCB: cmd_o.mon_step = !sts_i.mon_done;
      S_DIFF: cmd_o.diff = 1'b1;
      // wait for the output register to free up
      S_FIN:  cmd_o.finish = !valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      kind_q  <= '0;
    end else begin
      if (cmd_o.finish) valid_q <= 1'b1;
      else if (valid_q && out_ready_i) valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (cmd_o.load) begin
          kind_q  <= kind_i;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (sts_i.bad1 || sts_i.range1) state_q <= S_FIN;
          else begin
            case (kind_e'(kind_q))
              KIND_ADD: state_q <= S_ADD;
              KIND_SUB: state_q <= S_SUB;
              KIND_DIFF: state_q <= (sts_i.bad2 || sts_i.range2) ? S_FIN : S_NUMA;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_ADD: if (sts_i.add_done || sts_i.walk_over) state_q <= S_FIN;
        S_SUB: if (sts_i.sub_done || sts_i.walk_over) state_q <= S_FIN;
        S_NUMA: state_q <= S_ACCA;
        S_ACCA: if (sts_i.mon_done) state_q <= S_NUMB;
        S_NUMB: state_q <= S_ACCB;
        S_ACCB: if (sts_i.mon_done) state_q <= S_DIFF;
        S_DIFF: state_q <= S_FIN;
        S_FIN: if (cmd_o.finish) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/date_day_arithmetic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_day_arithmetic
// Validate a date, add or subtract days month by month, or give the day
// difference between two dates (every fourth year a leap year).
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | kind, day_in, month_in, year_in, day_count, other_*
//  rsp     | out | day_out, month_out, year_out, day_difference, status
//
//  Add/subtract: one month per cycle.
//  Difference: sums the month lengths before each date's month.
//  The month walker is the bottleneck; one word is in the engine at a time.
//  Reset clears the sequencer and the response valid; no clearing pass.
//  A stalled response holds its word; the next request is taken and walked,
//  and its result waits until the held word leaves.
// ----------------------------------------------------------------------------
module date_day_arithmetic (
  input  logic   clk_i,
  input  logic   rst_ni,
  dda_req_if.sink   req,
  dda_rsp_if.source rsp
);
  import dda_pkg::*;

  dda_cmd_t cmd;
  dda_sts_t sts;

  dda_datapath u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .kind_i   (req.kind),
    .day_i    (req.day_in),
    .month_i  (req.month_in),
    .year_i   (req.year_in),
    .count_i  (req.day_count),
    .oday_i   (req.other_day),
    .omonth_i (req.other_month),
    .oyear_i  (req.other_year),
    .sts_o    (sts),
    .day_o    (rsp.day_out),
    .month_o  (rsp.month_out),
    .year_o   (rsp.year_out),
    .diff_o   (rsp.day_difference),
    .status_o (rsp.status)
  );

  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .kind_i      (req.kind),
    .out_ready_i (rsp.ready),
    .out_valid_o (rsp.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped while stalled");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.add_step, cmd.sub_step, cmd.mon_step, cmd.finish}))
    else $error("conflicting datapath commands");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> rsp.valid) else $error("finish did not raise valid");
endmodule

>>> tb/sv/date_day_arithmetic_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_day_arithmetic_test
// Drives validate, add, subtract and difference requests through the date
// block with random gaps and stalls on both channels. A behavioral date
// calculator predicts each response word, and the response monitor compares
// every field against it.
// ----------------------------------------------------------------------------
module date_day_arithmetic_test;
  import dda_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] count;
    logic [4:0]  oday;
    logic [3:0]  omonth;
    logic [13:0] oyear;
  } date_req_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] diff;
    status_e     status;
  } date_rsp_t;

  logic clk_i;
  logic rst_ni;

  dda_req_if req_ch ();
  dda_rsp_if rsp_ch ();

  date_day_arithmetic u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .rsp    (rsp_ch.source)
  );

  date_req_t pending_reqs[$];
  date_rsp_t expected_dates[$];
  int        error_count = 0;
  bit        stim_done = 0;
  int        hold_off_cycles = 0;
  bit        long_hold_req = 0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int days_in_month(int m, int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return (y % 4 == 0) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit valid_date(int d, int m, int y);
    return m >= 1 && m <= 12 && d >= 1 && d <= days_in_month(m, y);
  endfunction

  function automatic int serial_day(int d, int m, int y);
    int n;
    n = (y - 1) * 365 + (y - 1) / 4 + d;
    for (int i = 1; i < m; i++) n += days_in_month(i, y);
    return n;
  endfunction

  function automatic date_rsp_t calc_date(date_req_t r);
    date_rsp_t res;
    int d, m, y, k, a, b, diff;
    status_e st;
    d = r.day; m = r.month; y = r.year; k = r.count;
    diff = 0;
    st = ST_OK;
    if (!valid_date(d, m, y)) begin
      st = ST_INVALID;
    end else if (y < 1 || y > 9999) begin
      st = ST_RANGE;
    end else if (r.kind == KIND_ADD) begin
      d += k;
      while (d > days_in_month(m, y)) begin
        d -= days_in_month(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
          if (y > 9999) begin
            st = ST_RANGE;
            break;
          end
        end
      end
    end else if (r.kind == KIND_SUB) begin
      while (k > 0) begin
        if (d > k) begin
          d -= k;
          k = 0;
        end else begin
          k -= d;
          m--;
          if (m == 0) begin
            m = 12;
            if (y == 1) begin
              st = ST_RANGE;
              break;
            end
            y--;
          end
          d = days_in_month(m, y);
        end
      end
    end else if (r.kind == KIND_DIFF) begin
      if (!valid_date(r.oday, r.omonth, r.oyear)) begin
        st = ST_INVALID;
      end else if (r.oyear < 1 || r.oyear > 9999) begin
        st = ST_RANGE;
      end else begin
        a = serial_day(d, m, y);
        b = serial_day(r.oday, r.omonth, r.oyear);
        if (a < b) st = ST_NEGATIVE;
        else diff = a - b;
      end
    end
    if (st == ST_RANGE) begin
      d = 0; m = 0; y = 0;
    end
    res.day = d[4:0];
    res.month = m[3:0];
    res.year = y[13:0];
    res.diff = diff[21:0];
    res.status = st;
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic date_req_t rand_req();
    date_req_t r;
    int sel;
    r.kind = kind_e'($urandom_range(0, 3));
    r.year = 14'($urandom_range(1, 9999));
    r.month = 4'($urandom_range(1, 12));
    r.day = 5'($urandom_range(1, days_in_month(r.month, r.year)));
    sel = $urandom_range(0, 9);
    if (sel < 6) r.count = 16'($urandom_range(0, 800));
    else if (sel < 9) r.count = 16'($urandom_range(0, 65535));
    else r.count = 16'hffff;
    r.oyear = ($urandom_range(0, 1) == 1) ? r.year + 14'($urandom_range(0, 4)) - 14'd2
                                          : 14'($urandom_range(1, 9999));
    if (r.oyear < 1 || r.oyear > 9999) r.oyear = 14'd1;
    r.omonth = 4'($urandom_range(1, 12));
    r.oday = 5'($urandom_range(1, days_in_month(r.omonth, r.oyear)));
    sel = $urandom_range(0, 19);
    // noise: malformed fields and edge years
    if (sel == 0) r.day = 5'($urandom);
    else if (sel == 1) r.month = 4'($urandom);
    else if (sel == 2) r.year = 14'($urandom);
    else if (sel == 3) r.oday = 5'($urandom);
    else if (sel == 4) r.omonth = 4'($urandom);
    else if (sel == 5) r.oyear = 14'($urandom);
    else if (sel == 6) r.year = ($urandom_range(0, 1) == 1) ? 14'd9999 : 14'd1;
    return r;
  endfunction

  function automatic date_req_t mk(kind_e k, int d, int m, int y, int c,
                                   int od, int om, int oy);
    date_req_t r;
    r.kind = k; r.day = d[4:0]; r.month = m[3:0]; r.year = y[13:0];
    r.count = c[15:0]; r.oday = od[4:0]; r.omonth = om[3:0]; r.oyear = oy[13:0];
    return r;
  endfunction

  // driver
  int gap_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      gap_cnt <= 0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the word
    end else if (gap_cnt > 0) begin
      req_ch.valid <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else if (pending_reqs.size() > 0) begin
      date_req_t r;
      r = pending_reqs.pop_front();
      expected_dates.push_back(calc_date(r));
      req_ch.valid <= 1'b1;
      req_ch.kind <= r.kind;
      req_ch.day_in <= r.day;
      req_ch.month_in <= r.month;
      req_ch.year_in <= r.year;
      req_ch.day_count <= r.count;
      req_ch.other_day <= r.oday;
      req_ch.other_month <= r.omonth;
      req_ch.other_year <= r.oyear;
      gap_cnt <= gap_len();
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // receiver stall counter, own process
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_cycles <= 0;
      rsp_ch.ready <= 1'b0;
    end else if (long_hold_req && hold_off_cycles == 0) begin
      hold_off_cycles <= 300;
      rsp_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp_ch.ready <= (hold_off_cycles == 1);
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_ch.ready <= 1'b0;
      hold_off_cycles <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected response word day %0d month %0d year %0d", $realtime,
                 rsp_ch.day_out, rsp_ch.month_out, rsp_ch.year_out);
        error_count <= error_count + 1;
      end else begin
        date_rsp_t e;
        e = expected_dates.pop_front();
        if (rsp_ch.day_out !== e.day || rsp_ch.month_out !== e.month ||
            rsp_ch.year_out !== e.year || rsp_ch.day_difference !== e.diff ||
            rsp_ch.status !== e.status) begin
          $display("%0t: mismatch expected d%0d m%0d y%0d diff %0d st %0d", $realtime,
                   e.day, e.month, e.year, e.diff, e.status);
          $display("%0t:          actual   d%0d m%0d y%0d diff %0d st %0d", $realtime,
                   rsp_ch.day_out, rsp_ch.month_out, rsp_ch.year_out,
                   rsp_ch.day_difference, rsp_ch.status);
          error_count <= error_count + 1;
        end
      end
    end
  end

  initial begin
    req_ch.kind = KIND_VALIDATE;
    req_ch.day_in = '0; req_ch.month_in = '0; req_ch.year_in = '0;
    req_ch.day_count = '0; req_ch.other_day = '0; req_ch.other_month = '0;
    req_ch.other_year = '0;
    req_ch.valid = 1'b0;
    rsp_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_reqs.push_back(mk(KIND_VALIDATE, 29, 2, 4, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_VALIDATE, 29, 2, 5, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_VALIDATE, 0, 1, 100, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_VALIDATE, 31, 15, 16383, 0, 31, 15, 16383));
    pending_reqs.push_back(mk(KIND_VALIDATE, 1, 1, 0, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_VALIDATE, 31, 12, 10000, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_ADD, 31, 12, 2000, 1, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_ADD, 28, 2, 2004, 1, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_ADD, 31, 1, 2003, 30, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_ADD, 15, 6, 9999, 200, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_ADD, 1, 1, 9900, 65535, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_ADD, 1, 1, 1, 65535, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_SUB, 1, 1, 2001, 1, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_SUB, 1, 3, 2004, 1, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_SUB, 5, 5, 2005, 5, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_SUB, 10, 1, 1, 10, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_SUB, 31, 12, 9999, 65535, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_SUB, 7, 7, 7, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_DIFF, 31, 12, 9999, 0, 1, 1, 1));
    pending_reqs.push_back(mk(KIND_DIFF, 1, 1, 1, 0, 31, 12, 9999));
    pending_reqs.push_back(mk(KIND_DIFF, 1, 3, 2004, 0, 28, 2, 2004));
    pending_reqs.push_back(mk(KIND_DIFF, 1, 3, 2004, 0, 30, 2, 2004));
    pending_reqs.push_back(mk(KIND_DIFF, 1, 3, 2004, 0, 1, 1, 0));
    pending_reqs.push_back(mk(KIND_DIFF, 1, 3, 2004, 0, 1, 1, 16383));
    pending_reqs.push_back(mk(KIND_DIFF, 3, 3, 3, 0, 3, 3, 3));

    // sender pause until everything has drained
    wait (pending_reqs.size() == 0 && expected_dates.size() == 0);
    @(posedge clk_i);

    // long receiver hold while the sender keeps offering words
    long_hold_req = 1'b1;
    for (int i = 0; i < 10; i++) pending_reqs.push_back(rand_req());
    wait (hold_off_cycles > 40);
    long_hold_req = 1'b0;

    for (int i = 0; i < 240; i++) begin
      pending_reqs.push_back(rand_req());
      if (i == 120) begin
        wait (pending_reqs.size() == 0 && expected_dates.size() == 0);
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && expected_dates.size() == 0);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && expected_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> date_day_arithmetic.f
hdl/dda_pkg.sv
hdl/dda_if.sv
hdl/dda_datapath.sv
hdl/dda_ctrl.sv
hdl/date_day_arithmetic.sv
tb/sv/date_day_arithmetic_test.sv
